/* hdl/i2cadc_pkg.sv */
package i2cadc_pkg;

   // Sample storage geometry
   localparam int MAX_CHANNELS      = 6;
   localparam int SAMPLE_BYTE_COUNT = 2 * MAX_CHANNELS;
   localparam int PTR_W             = $clog2(SAMPLE_BYTE_COUNT + 1);
   localparam int SLOT_W            = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

   // Fixed field widths
   localparam int KIND_W   = 3;
   localparam int BYTE_W   = 8;
   localparam int SLOT_IN_W = 3;
   localparam int SAMPLE_W = 16;
   localparam int ACT_CH_W = 3;
   localparam int CSR_IDX_W = 1;

   localparam logic [BYTE_W-1:0]   INVALID_REG_BYTE = 8'hFF;
   localparam logic [ACT_CH_W-1:0] ACTIVE_CH_RESET  = 3'd6;

   // Bus event codes
   typedef enum logic [KIND_W-1:0] {
      KIND_ADDR_MATCH = 3'd0,
      KIND_RX_BYTE    = 3'd1,
      KIND_TX_EMPTY   = 3'd2,
      KIND_STOP       = 3'd3,
      KIND_SAMPLE     = 3'd4
   } kind_type;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CONFIG_REG_ADDRESS = 1'b0,
      CSR_ACTIVE_CHANNELS    = 1'b1
   } csr_index_type;

   // Sample store write request
   typedef struct packed {
      logic                en;
      logic [SLOT_W-1:0]   slot;
      logic [SAMPLE_W-1:0] value;
   } sample_wr_type;

endpackage

/* hdl/i2cadc_if.sv */
interface i2cadc_req_if
   import i2cadc_pkg::*;
   ;
   logic                 valid;
   logic                 ready;
   logic [KIND_W-1:0]    kind;
   logic                 read_direction;
   logic [BYTE_W-1:0]    rx_byte;
   logic [SLOT_IN_W-1:0] channel_slot;
   logic [SAMPLE_W-1:0]  sample_value;

   modport source (output valid, kind, read_direction, rx_byte, channel_slot,
                   sample_value, input ready);
   modport sink   (input valid, kind, read_direction, rx_byte, channel_slot,
                   sample_value, output ready);
endinterface

interface i2cadc_rsp_if
   import i2cadc_pkg::*;
   ;
   logic              valid;
   logic              ready;
   logic              tx_valid;
   logic [BYTE_W-1:0] tx_byte;
   logic              tx_irq_enabled;
   logic              config_written;
   logic [BYTE_W-1:0] channel_config;

   modport source (output valid, tx_valid, tx_byte, tx_irq_enabled, config_written,
                   channel_config, input ready);
   modport sink   (input valid, tx_valid, tx_byte, tx_irq_enabled, config_written,
                   channel_config, output ready);
endinterface

/* hdl/i2cadc_sample_store.sv */
module i2cadc_sample_store
   import i2cadc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  sample_wr_type      wr,
   input  logic [PTR_W-1:0]   rd_ptr,
   output logic [BYTE_W-1:0]  rd_byte
);

   // One 16-bit word per channel slot, MSB byte at the even byte address
   logic [SAMPLE_W-1:0] slot_ff [MAX_CHANNELS];
   logic [SAMPLE_W-1:0] rd_word;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_CHANNELS; i++) begin
            slot_ff[i] <= '0;
         end
      end else if (wr.en) begin
         slot_ff[wr.slot] <= wr.value;
      end
   end

   // Byte read: caller keeps rd_ptr below the stored byte count
   assign rd_word = slot_ff[SLOT_W'(rd_ptr >> 1)];
   assign rd_byte = rd_ptr[0] ? rd_word[BYTE_W-1:0] : rd_word[SAMPLE_W-1:BYTE_W];

endmodule

/* hdl/i2c_target_adc_register_map_core.sv */
// Channel   Direction  Handshake          Carries
// req_chan  in         valid/ready        bus event or ADC sample
// rsp_chan  out        valid/ready        transmit byte, irq enable, config status
// csr_*     in         write enable only  config register address, active channels
//
// One item per cycle sustained while rsp_chan is ready; response valid rises once the request
// has passed the input register and then one pass of logic into the result register.
// Stalls on rsp_chan back up through the result register into the input register.
// Reset is synchronous; it clears sample bytes, pointers and config state.
module i2c_target_adc_register_map_core
   import i2cadc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   i2cadc_req_if.sink           req_chan,
   i2cadc_rsp_if.source         rsp_chan,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [BYTE_W-1:0]    csr_wdata
);

   // Configuration registers
   logic [BYTE_W-1:0]   cfg_addr_ff;
   logic [ACT_CH_W-1:0] active_ch_ff;

   // Input register
   logic                 in_valid_ff;
   logic [KIND_W-1:0]    in_kind_ff;
   logic                 in_read_ff;
   logic [BYTE_W-1:0]    in_rx_byte_ff;
   logic [SLOT_IN_W-1:0] in_slot_ff;
   logic [SAMPLE_W-1:0]  in_sample_ff;

   // Block state
   logic              rx_pending_ff, rx_pending_in;
   logic [BYTE_W-1:0] rx_reg_ff, rx_reg_in;
   logic              sending_ff, sending_in;
   logic [PTR_W-1:0]  read_ptr_ff, read_ptr_in;
   logic [BYTE_W-1:0] config_ff, config_in;
   logic              tx_en_ff, tx_en_in;

   // Result register
   logic              out_valid_ff;
   logic              out_tx_valid_ff, out_tx_valid_in;
   logic [BYTE_W-1:0] out_tx_byte_ff, out_tx_byte_in;
   logic              out_cfg_wr_ff, out_cfg_wr_in;

   logic              advance;
   logic [PTR_W-1:0]  stream_end;
   logic [BYTE_W-1:0] sample_byte;
   sample_wr_type     sample_wr;

   assign advance       = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;

   // Config writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_addr_ff  <= '0;
         active_ch_ff <= ACTIVE_CH_RESET;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_CONFIG_REG_ADDRESS: cfg_addr_ff  <= csr_wdata;
            CSR_ACTIVE_CHANNELS:    active_ch_ff <= csr_wdata[ACT_CH_W-1:0];
            default:                ;
         endcase
      end
   end

   // Input register capture
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_kind_ff    <= req_chan.kind;
         in_read_ff    <= req_chan.read_direction;
         in_rx_byte_ff <= req_chan.rx_byte;
         in_slot_ff    <= req_chan.channel_slot;
         in_sample_ff  <= req_chan.sample_value;
      end
   end

   // Stream length, with active channels clamped to the slot count
   always_comb begin
      if (int'(active_ch_ff) > MAX_CHANNELS) begin
         stream_end = PTR_W'(SAMPLE_BYTE_COUNT);
      end else begin
         stream_end = PTR_W'(32'(active_ch_ff) << 1);
      end
   end

   i2cadc_sample_store u_store (
      .clock   (clock),
      .reset   (reset),
      .wr      (sample_wr),
      .rd_ptr  (read_ptr_ff),
      .rd_byte (sample_byte)
   );

   // Event handling
   always_comb begin
      rx_pending_in   = rx_pending_ff;
      rx_reg_in       = rx_reg_ff;
      sending_in      = sending_ff;
      read_ptr_in     = read_ptr_ff;
      config_in       = config_ff;
      tx_en_in        = tx_en_ff;
      out_tx_valid_in = 1'b0;
      out_tx_byte_in  = '0;
      out_cfg_wr_in   = 1'b0;
      sample_wr       = '0;

      if (advance) begin
         case (in_kind_ff)
            KIND_ADDR_MATCH: begin
               if (in_read_ff) begin
                  if (rx_pending_ff) begin
                     out_tx_byte_in  = (rx_reg_ff == cfg_addr_ff) ? config_ff
                                                                  : INVALID_REG_BYTE;
                     out_tx_valid_in = 1'b1;
                     rx_pending_in   = 1'b0;
                  end else begin
                     sending_in  = 1'b1;
                     read_ptr_in = '0;
                  end
                  tx_en_in = 1'b1;
               end
            end
            KIND_RX_BYTE: begin
               if (!rx_pending_ff) begin
                  rx_reg_in     = in_rx_byte_ff;
                  rx_pending_in = 1'b1;
               end else begin
                  // second byte of register+data write
                  if (rx_reg_ff == cfg_addr_ff) begin
                     config_in     = in_rx_byte_ff;
                     out_cfg_wr_in = 1'b1;
                  end
                  rx_pending_in = 1'b0;
               end
            end
            KIND_TX_EMPTY: begin
               if (sending_ff) begin
                  if (read_ptr_ff >= stream_end ||
                      int'(read_ptr_ff) >= SAMPLE_BYTE_COUNT) begin
                     sending_in = 1'b0;
                     tx_en_in   = 1'b0;
                  end else begin
                     out_tx_byte_in  = sample_byte;
                     out_tx_valid_in = 1'b1;
                     read_ptr_in     = read_ptr_ff + PTR_W'(1);
                  end
               end else begin
                  tx_en_in = 1'b0;
               end
            end
            KIND_SAMPLE: begin
               if (int'(in_slot_ff) < MAX_CHANNELS) begin
                  sample_wr.en    = 1'b1;
                  sample_wr.slot  = SLOT_W'(in_slot_ff);
                  sample_wr.value = in_sample_ff;
               end
            end
            default: ; // stop and unused codes leave state alone
         endcase
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rx_pending_ff <= 1'b0;
         sending_ff    <= 1'b0;
         read_ptr_ff   <= '0;
         config_ff     <= '0;
         tx_en_ff      <= 1'b0;
      end else begin
         rx_pending_ff <= rx_pending_in;
         sending_ff    <= sending_in;
         read_ptr_ff   <= read_ptr_in;
         config_ff     <= config_in;
         tx_en_ff      <= tx_en_in;
      end
   end

   always_ff @(posedge clock) begin
      rx_reg_ff <= rx_reg_in;
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_tx_valid_ff <= out_tx_valid_in;
         out_tx_byte_ff  <= out_tx_byte_in;
         out_cfg_wr_ff   <= out_cfg_wr_in;
      end
   end

   // Irq enable and config byte read straight from state, which only moves on advance
   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.tx_valid       = out_tx_valid_ff;
   assign rsp_chan.tx_byte        = out_tx_byte_ff;
   assign rsp_chan.tx_irq_enabled = tx_en_ff;
   assign rsp_chan.config_written = out_cfg_wr_ff;
   assign rsp_chan.channel_config = config_ff;

endmodule

/* hdl/i2cadc_checker.sv */
module i2cadc_checker
   import i2cadc_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic              tx_valid,
   input logic [BYTE_W-1:0] tx_byte,
   input logic              tx_irq_enabled,
   input logic              config_written,
   input logic [BYTE_W-1:0] channel_config
);

   // Stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(tx_byte) && $stable(tx_valid)
         && $stable(config_written) && $stable(channel_config))
      else $error("response changed while stalled");

   // No byte loaded means a zero byte
   a_idle_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !tx_valid |-> tx_byte == '0)
      else $error("tx_byte nonzero without tx_valid");

   // A config write never also loads a transmit byte
   a_cfg_no_tx: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && config_written |-> !tx_valid)
      else $error("config write and transmit in one transfer");

   // Transmit is only loaded while transmit interrupts are enabled
   a_tx_irq: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && tx_valid |-> tx_irq_enabled)
      else $error("byte loaded with transmit disabled");

endmodule

bind i2c_target_adc_register_map_core i2cadc_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .tx_valid       (rsp_chan.tx_valid),
   .tx_byte        (rsp_chan.tx_byte),
   .tx_irq_enabled (rsp_chan.tx_irq_enabled),
   .config_written (rsp_chan.config_written),
   .channel_config (rsp_chan.channel_config)
);

/* tb/register_map_checker.sv */
`timescale 1ns / 100ps

// Watches the request, response and register ports of the ADC register map,
// keeps its own copy of the map state and checks every response transfer
// against the oldest predicted one.
module register_map_checker
   import i2cadc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   i2cadc_req_if                req_chan,
   i2cadc_rsp_if                rsp_chan,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [BYTE_W-1:0]    csr_wdata,
   output int                   fail_count,
   output int                   outstanding
);

   typedef struct packed {
      logic              tx_valid;
      logic [BYTE_W-1:0] tx_byte;
      logic              tx_irq_enabled;
      logic              config_written;
      logic [BYTE_W-1:0] channel_config;
   } bus_response_type;

   // Register copies
   logic [BYTE_W-1:0]   cfg_reg_addr;
   logic [ACT_CH_W-1:0] cfg_active_ch;

   // Map state
   logic [1:0]        rx_cnt;
   logic [BYTE_W-1:0] rx_buf [2];
   logic              streaming;
   int                rd_ptr;
   logic [BYTE_W-1:0] sample_bytes [SAMPLE_BYTE_COUNT];
   logic [BYTE_W-1:0] cfg_byte;
   logic              tx_irq_on;

   bus_response_type responses_due [$];

   // Advance the map by one bus event or sample, return what it reports
   function automatic bus_response_type predict_bus_response(
      logic [KIND_W-1:0]    kind,
      logic                 rd,
      logic [BYTE_W-1:0]    rxb,
      logic [SLOT_IN_W-1:0] slot,
      logic [SAMPLE_W-1:0]  smp
   );
      bus_response_type r;
      int               stop_at;
      r = '0;
      case (kind)
         KIND_ADDR_MATCH: begin
            if (rd) begin
               if (rx_cnt != 2'd0) begin
                  // register byte pending: answer with config or invalid marker
                  r.tx_valid = 1'b1;
                  r.tx_byte  = (rx_buf[0] == cfg_reg_addr) ? cfg_byte : INVALID_REG_BYTE;
                  rx_cnt     = '0;
               end else begin
                  streaming = 1'b1;
                  rd_ptr    = 0;
               end
               tx_irq_on = 1'b1;
            end
         end
         KIND_RX_BYTE: begin
            if (rx_cnt >= 2'd2) rx_cnt = '0;
            rx_buf[rx_cnt[0]] = rxb;
            rx_cnt = rx_cnt + 2'd1;
            if (rx_cnt == 2'd2) begin
               if (rx_buf[0] == cfg_reg_addr) begin
                  cfg_byte         = rx_buf[1];
                  r.config_written = 1'b1;
               end
               rx_cnt = '0;
            end
         end
         KIND_TX_EMPTY: begin
            // stream length clamps at the stored sample bytes
            stop_at = 2 * ((cfg_active_ch > MAX_CHANNELS) ? MAX_CHANNELS : int'(cfg_active_ch));
            if (!streaming) begin
               tx_irq_on = 1'b0;
            end else if (rd_ptr >= stop_at || rd_ptr >= SAMPLE_BYTE_COUNT) begin
               streaming = 1'b0;
               tx_irq_on = 1'b0;
            end else begin
               r.tx_valid = 1'b1;
               r.tx_byte  = sample_bytes[rd_ptr];
               rd_ptr     = rd_ptr + 1;
            end
         end
         KIND_SAMPLE: begin
            if (slot < MAX_CHANNELS) begin
               sample_bytes[2 * slot]     = smp[15:8];
               sample_bytes[2 * slot + 1] = smp[7:0];
            end
         end
         default: ;
      endcase
      r.tx_irq_enabled = tx_irq_on;
      r.channel_config = cfg_byte;
      return r;
   endfunction

   task automatic check_field(string field, logic [BYTE_W-1:0] want, logic [BYTE_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", field, want, got);
         fail_count = fail_count + 1;
      end
   endtask

   // Predict on request transfers, compare on response transfers
   always @(posedge clock) begin
      bus_response_type got;
      bus_response_type want;
      if (reset) begin
         cfg_reg_addr  = '0;
         cfg_active_ch = ACTIVE_CH_RESET;
         rx_cnt        = '0;
         rx_buf[0]     = '0;
         rx_buf[1]     = '0;
         streaming     = 1'b0;
         rd_ptr        = 0;
         for (int i = 0; i < SAMPLE_BYTE_COUNT; i++) sample_bytes[i] = '0;
         cfg_byte      = '0;
         tx_irq_on     = 1'b0;
         fail_count    = 0;
         responses_due.delete();
         outstanding <= 0;
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_CONFIG_REG_ADDRESS) cfg_reg_addr = csr_wdata;
            else cfg_active_ch = csr_wdata[ACT_CH_W-1:0];
         end
         if (req_chan.valid && req_chan.ready) begin
            responses_due.push_back(predict_bus_response(req_chan.kind, req_chan.read_direction,
               req_chan.rx_byte, req_chan.channel_slot, req_chan.sample_value));
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            got = '{rsp_chan.tx_valid, rsp_chan.tx_byte, rsp_chan.tx_irq_enabled,
                    rsp_chan.config_written, rsp_chan.channel_config};
            if (responses_due.size() == 0) begin
               $error("response transfer with no response due");
               fail_count = fail_count + 1;
            end else begin
               want = responses_due.pop_front();
               check_field("tx_valid", 8'(want.tx_valid), 8'(got.tx_valid));
               check_field("tx_byte", want.tx_byte, got.tx_byte);
               check_field("tx_irq_enabled", 8'(want.tx_irq_enabled), 8'(got.tx_irq_enabled));
               check_field("config_written", 8'(want.config_written), 8'(got.config_written));
               check_field("channel_config", want.channel_config, got.channel_config);
            end
         end
         outstanding <= responses_due.size();
      end
   end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
   import i2cadc_pkg::*;

   localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [BYTE_W-1:0]    csr_wdata;
   int                   fail_count;
   int                   outstanding;

   int                   req_idle_pct;
   int                   rsp_stall_pct;
   int                   items_sent;
   logic [BYTE_W-1:0]    cur_reg_addr;
   logic [ACT_CH_W-1:0]  cur_active_ch;

   i2cadc_req_if req_if ();
   i2cadc_rsp_if rsp_if ();

   i2c_target_adc_register_map_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   register_map_checker u_check (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Response side back-pressure
   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // One request transfer, after an optional random gap
   task automatic send_item(logic [KIND_W-1:0] kind, logic rd, logic [BYTE_W-1:0] rxb,
                            logic [SLOT_IN_W-1:0] slot, logic [SAMPLE_W-1:0] smp);
      while ($urandom_range(99) < req_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid          <= 1'b1;
      req_if.kind           <= kind;
      req_if.read_direction <= rd;
      req_if.rx_byte        <= rxb;
      req_if.channel_slot   <= slot;
      req_if.sample_value   <= smp;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      items_sent++;
   endtask

   // Let everything in flight come out
   task automatic wait_until_idle();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic apply_config(logic [BYTE_W-1:0] reg_addr, logic [ACT_CH_W-1:0] act_ch);
      csr_we    <= 1'b1;
      csr_index <= CSR_CONFIG_REG_ADDRESS;
      csr_wdata <= reg_addr;
      @(posedge clock);
      csr_index <= CSR_ACTIVE_CHANNELS;
      csr_wdata <= BYTE_W'(act_ch);
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      cur_reg_addr  = reg_addr;
      cur_active_ch = act_ch;
   endtask

   // Corners with the reset configuration
   task automatic run_directed();
      send_item(KIND_SAMPLE, 1'b0, 8'h00, 3'd0, 16'hFFFF);
      send_item(KIND_SAMPLE, 1'b1, 8'hFF, 3'd5, 16'h0000);
      // slot past the last channel is dropped
      send_item(KIND_SAMPLE, 1'b0, 8'h00, 3'd7, 16'hFFFF);
      send_item(KIND_ADDR_MATCH, 1'b0, 8'hFF, 3'd7, 16'hFFFF);
      send_item(KIND_STOP, 1'b1, 8'hFF, 3'd7, 16'hFFFF);
      send_item(KIND_UNUSED, 1'b1, 8'hFF, 3'd7, 16'hFFFF);
      // full sample stream, then one more to switch transmit off
      send_item(KIND_ADDR_MATCH, 1'b1, 8'h00, 3'd0, 16'h0000);
      repeat (2 * MAX_CHANNELS + 1) send_item(KIND_TX_EMPTY, 1'b0, 8'h00, 3'd0, 16'h0000);
      // config write through the bus
      send_item(KIND_RX_BYTE, 1'b0, 8'h00, 3'd0, 16'h0000);
      send_item(KIND_RX_BYTE, 1'b0, 8'hC3, 3'd0, 16'h0000);
      // register read from another address, then from the config address
      send_item(KIND_RX_BYTE, 1'b0, 8'hFF, 3'd0, 16'h0000);
      send_item(KIND_ADDR_MATCH, 1'b1, 8'h00, 3'd0, 16'h0000);
      send_item(KIND_RX_BYTE, 1'b0, 8'h00, 3'd0, 16'h0000);
      send_item(KIND_ADDR_MATCH, 1'b1, 8'h00, 3'd0, 16'h0000);
      // transmit empty with no stream running
      send_item(KIND_TX_EMPTY, 1'b0, 8'h00, 3'd0, 16'h0000);
   endtask

   // Mostly well-formed bus transactions with random content, some noise
   task automatic run_random_traffic(int n_items);
      int start;
      int pick;
      int n;
      start = items_sent;
      while (items_sent - start < n_items) begin
         pick = $urandom_range(99);
         if (pick < 25) begin
            // register + data write
            send_item(KIND_ADDR_MATCH, 1'b0, BYTE_W'($urandom), SLOT_IN_W'($urandom),
                      SAMPLE_W'($urandom));
            send_item(KIND_RX_BYTE, 1'($urandom), ($urandom_range(3) != 0) ? cur_reg_addr
                      : BYTE_W'($urandom), SLOT_IN_W'($urandom), SAMPLE_W'($urandom));
            send_item(KIND_RX_BYTE, 1'($urandom), BYTE_W'($urandom), SLOT_IN_W'($urandom),
                      SAMPLE_W'($urandom));
            send_item(KIND_STOP, 1'($urandom), BYTE_W'($urandom), SLOT_IN_W'($urandom),
                      SAMPLE_W'($urandom));
         end else if (pick < 45) begin
            // register read
            send_item(KIND_ADDR_MATCH, 1'b0, BYTE_W'($urandom), SLOT_IN_W'($urandom),
                      SAMPLE_W'($urandom));
            send_item(KIND_RX_BYTE, 1'($urandom), ($urandom_range(1) != 0) ? cur_reg_addr
                      : BYTE_W'($urandom), SLOT_IN_W'($urandom), SAMPLE_W'($urandom));
            send_item(KIND_ADDR_MATCH, 1'b1, BYTE_W'($urandom), SLOT_IN_W'($urandom),
                      SAMPLE_W'($urandom));
            n = $urandom_range(2);
            repeat (n) send_item(KIND_TX_EMPTY, 1'($urandom), BYTE_W'($urandom),
                                 SLOT_IN_W'($urandom), SAMPLE_W'($urandom));
            send_item(KIND_STOP, 1'($urandom), BYTE_W'($urandom), SLOT_IN_W'($urandom),
                      SAMPLE_W'($urandom));
         end else if (pick < 70) begin
            // sample stream read, sometimes cut short or run past the end
            send_item(KIND_ADDR_MATCH, 1'b1, BYTE_W'($urandom), SLOT_IN_W'($urandom),
                      SAMPLE_W'($urandom));
            n = $urandom_range(2 * cur_active_ch + 2);
            repeat (n) send_item(KIND_TX_EMPTY, 1'($urandom), BYTE_W'($urandom),
                                 SLOT_IN_W'($urandom), SAMPLE_W'($urandom));
            send_item(KIND_STOP, 1'($urandom), BYTE_W'($urandom), SLOT_IN_W'($urandom),
                      SAMPLE_W'($urandom));
         end else if (pick < 88) begin
            n = $urandom_range(1, 3);
            repeat (n) begin
               send_item(KIND_SAMPLE, 1'($urandom), BYTE_W'($urandom),
                         ($urandom_range(7) == 0) ? SLOT_IN_W'($urandom_range(7, 6))
                         : SLOT_IN_W'($urandom_range(MAX_CHANNELS - 1)), SAMPLE_W'($urandom));
            end
         end else begin
            send_item(KIND_W'($urandom_range(7)), 1'($urandom), BYTE_W'($urandom),
                      SLOT_IN_W'($urandom), SAMPLE_W'($urandom));
         end
      end
   endtask

   // Stimulus and verdict
   initial begin
      reset                 <= 1'b1;
      csr_we                <= 1'b0;
      csr_index             <= CSR_CONFIG_REG_ADDRESS;
      csr_wdata             <= '0;
      req_if.valid          <= 1'b0;
      req_if.kind           <= KIND_STOP;
      req_if.read_direction <= 1'b0;
      req_if.rx_byte        <= '0;
      req_if.channel_slot   <= '0;
      req_if.sample_value   <= '0;
      req_idle_pct  = 17;
      rsp_stall_pct = 73;
      items_sent    = 0;
      cur_reg_addr  = '0;
      cur_active_ch = ACTIVE_CH_RESET;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();
      wait_until_idle();

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: apply_config(8'hFF, 3'd0);
            1: apply_config(8'h00, 3'd6);
            2: apply_config(BYTE_W'($urandom), 3'd7);
            3: apply_config(BYTE_W'($urandom), 3'd1);
            4: apply_config(BYTE_W'($urandom), ACT_CH_W'($urandom_range(6)));
            default: apply_config(BYTE_W'($urandom), ACT_CH_W'($urandom_range(7)));
         endcase
         // idle pattern: sender light / receiver heavy, then swapped, then none
         if (phase < 2) begin
            req_idle_pct  = 17;
            rsp_stall_pct = 73;
         end else if (phase < 4) begin
            req_idle_pct  = 73;
            rsp_stall_pct = 17;
         end else begin
            req_idle_pct  = 0;
            rsp_stall_pct = 0;
         end
         run_random_traffic(285);
         wait_until_idle();
      end

      if (fail_count == 0 && outstanding == 0) begin
         $display("** i2c_target_adc_register_map_core: PASSED **");
      end else begin
         $display("** i2c_target_adc_register_map_core: FAILED **");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #(5_000_000);
      $display("** i2c_target_adc_register_map_core: FAILED **");
      $finish;
   end

endmodule
